// ===== rtl/bitmap_slot_allocator_defines.svh =====
// assertion macros for the bitmap slot allocator
// no dependencies; taken in by files that carry concurrent assertions
`ifndef BITMAP_SLOT_ALLOCATOR_DEFINES_SVH
`define BITMAP_SLOT_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked at every rising edge outside reset
`define BSA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_slot_allocator: implication check failed");

// next-cycle implication
`define BSA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_slot_allocator: next-cycle check failed");

`else

`define BSA_ASSERT_IMP(label, clk, rst, ante, cons)
`define BSA_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/bsa_pkg.sv =====
// shared types, widths and codes for the bitmap slot allocator
// no dependencies; imported by bsa_div and bitmap_slot_allocator
`timescale 1ns / 1ps

package bsa_pkg;

   // slot bound and the free map geometry derived from it
   localparam int MAX_SLOTS = 256;
   localparam int WORD_W    = 32;
   localparam int BIT_W     = $clog2(WORD_W);
   localparam int ROWS      = (MAX_SLOTS + WORD_W - 1) / WORD_W;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int SLOT_W    = ROW_W + BIT_W;

   // field widths
   localparam int ADDR_W    = 32;
   localparam int SIZE_W    = 13;
   localparam int COUNT_W   = 9;
   localparam int CSR_IDX_W = 2;

   // arithmetic widths
   localparam int EFF_W     = $clog2(MAX_SLOTS + 1);
   localparam int SPAN_W    = EFF_W + SIZE_W;
   localparam int PROD_W    = SLOT_W + SIZE_W;
   localparam int REM_W     = SIZE_W + SLOT_W;
   localparam int DIV_CNT_W = $clog2(SLOT_W);

   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_ADDRESS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_SIZE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_COUNT   = 2'd2;

   // register reset values
   localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd0;
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 13'd16;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   // request kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_ALLOCATED = 3'd0,
      ST_FULL      = 3'd1,
      ST_FREED     = 3'd2,
      ST_NULL      = 3'd3,
      ST_FAULT     = 3'd4
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] slot_address;
      status_type        status;
   } rsp_type;

endpackage

// ===== rtl/bsa_div.sv =====
// restoring divider, one quotient bit per cycle, for the slot index of a free
// depends on bsa_pkg
`timescale 1ns / 1ps

module bsa_div
   import bsa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [REM_W-1:0]  dividend,
   input  logic [SIZE_W-1:0] divisor,
   output logic              done,
   output logic [SLOT_W-1:0] quotient
);

   logic                 run_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [REM_W-1:0]     rem_ff;
   logic [REM_W-1:0]     dsh_ff;
   logic [SLOT_W-1:0]    quo_ff;
   logic                 take;

   // take the quotient bit when the remainder reaches the divisor shifted to that bit
   assign take = (rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= DIV_CNT_W'(SLOT_W - 1);
            rem_ff <= dividend;
            dsh_ff <= REM_W'(divisor) << (SLOT_W - 1);
            quo_ff <= '0;
         end else if (run_ff) begin
            if (take) begin
               rem_ff <= rem_ff - dsh_ff;
            end
            quo_ff <= {quo_ff[SLOT_W-2:0], take};
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/bitmap_slot_allocator.sv =====
// an allocation reads the free map from row 0 up until a row holds a free slot, then
// forms the address by multiply and add, or answers full after the last row; a free runs
// span multiply, range check, 8 divider steps, then read-modify-write (fault answered at
// the range check, address zero from idle). one request at a time: busy falls in the
// strobe cycle. synchronous reset marks every slot free through per-row valid bits
// without a clearing pass; results cannot be stalled
`timescale 1ns / 1ps
`include "bitmap_slot_allocator_defines.svh"

module bitmap_slot_allocator
   import bsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request side
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   // result side
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   // register writes
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_wdata
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC_RD,
      S_ALLOC_CHK,
      S_ALLOC_MUL,
      S_ALLOC_ADD,
      S_FREE_MUL,
      S_FREE_CHK,
      S_FREE_DIV,
      S_FREE_RD,
      S_FREE_WR
   } state_type;

   // configuration registers
   logic [ADDR_W-1:0]  base_address_ff;
   logic [SIZE_W-1:0]  slot_size_ff;
   logic [COUNT_W-1:0] slot_count_ff;

   // control and working registers
   state_type          state_ff;
   req_type            req_ff;
   logic [ROW_W-1:0]   row_ff;
   logic [BIT_W-1:0]   bit_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [SPAN_W-1:0]  span_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   // free map: one word per row, read data registered
   logic [WORD_W-1:0]  map_mem [ROWS];
   logic [ROWS-1:0]    row_valid_ff;
   logic [WORD_W-1:0]  rd_word_ff;
   logic               rd_vld_ff;

   // combinational helpers
   logic [EFF_W-1:0]   n_eff;
   logic [WORD_W-1:0]  rd_eff;
   logic [WORD_W-1:0]  active;
   logic [WORD_W-1:0]  avail;
   logic               hit;
   logic [BIT_W-1:0]   hit_bit;
   logic               mem_re;
   logic               mem_we;
   logic [WORD_W-1:0]  mem_wdata;
   logic [ADDR_W:0]    hi_bound;
   logic               fault;
   logic [ADDR_W-1:0]  offset;
   logic               div_start;
   logic               div_done;
   logic [SLOT_W-1:0]  div_quot;

   // ---------------------------------------------------------------------------
   // register writes; an index past the list is dropped
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff <= BASE_RESET;
         slot_size_ff    <= SIZE_RESET;
         slot_count_ff   <= COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_address_ff <= csr_wdata;
            CSR_SLOT_SIZE:    slot_size_ff    <= csr_wdata[SIZE_W-1:0];
            CSR_SLOT_COUNT:   slot_count_ff   <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // a slot count above the bound acts as the bound
   assign n_eff = (int'(slot_count_ff) > MAX_SLOTS) ? EFF_W'(MAX_SLOTS)
                                                    : EFF_W'(slot_count_ff);

   // ---------------------------------------------------------------------------
   // free map memory; a row never written since reset reads as all free
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[row_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rd_word_ff <= map_mem[row_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (mem_we) begin
         row_valid_ff[row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_vld_ff <= row_valid_ff[row_ff];
      end
   end

   assign rd_eff = rd_vld_ff ? rd_word_ff : '1;

   // ---------------------------------------------------------------------------
   // lowest free slot in the word just read, limited to the effective count
   // ---------------------------------------------------------------------------
   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         active[b] = (int'({row_ff, BIT_W'(b)}) < int'(n_eff));
      end
      avail   = rd_eff & active;
      hit     = |avail;
      hit_bit = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            hit_bit = BIT_W'(b);
         end
      end
   end

   assign mem_re = (state_ff == S_ALLOC_RD) || (state_ff == S_FREE_RD);

   always_comb begin
      mem_we    = 1'b0;
      mem_wdata = rd_eff;
      if ((state_ff == S_ALLOC_CHK) && hit) begin
         mem_we    = 1'b1;
         mem_wdata = rd_eff & ~(WORD_W'(1) << hit_bit);
      end else if (state_ff == S_FREE_WR) begin
         mem_we    = 1'b1;
         mem_wdata = rd_eff | (WORD_W'(1) << bit_ff);
      end
   end

   // ---------------------------------------------------------------------------
   // range check for a free: exact upper bound, no wrap
   // ---------------------------------------------------------------------------
   assign hi_bound  = {1'b0, base_address_ff} + (ADDR_W + 1)'(span_ff);
   assign fault     = (req_ff.free_address < base_address_ff)
                   || ({1'b0, req_ff.free_address} >= hi_bound)
                   || (slot_size_ff == '0);
   assign offset    = req_ff.free_address - base_address_ff;
   assign div_start = (state_ff == S_FREE_CHK) && !fault;

   // offset lies below count times size, so the quotient fits a slot index
   bsa_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (REM_W'(offset)),
      .divisor  (slot_size_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // ---------------------------------------------------------------------------
   // sequencer and registered result beat
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  row_ff <= '0;
                  if (req_data.kind == KIND_ALLOC) begin
                     state_ff <= S_ALLOC_RD;
                  end else if (req_data.free_address == '0) begin
                     // null pointer: answered straight away
                     rsp_valid_ff             <= 1'b1;
                     rsp_data_ff.slot_address <= '0;
                     rsp_data_ff.status       <= ST_NULL;
                  end else begin
                     state_ff <= S_FREE_MUL;
                  end
               end
            end
            S_ALLOC_RD: begin
               state_ff <= S_ALLOC_CHK;
            end
            S_ALLOC_CHK: begin
               priority if (hit) begin
                  bit_ff   <= hit_bit;
                  state_ff <= S_ALLOC_MUL;
               end else if (row_ff == LAST_ROW) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.slot_address <= '0;
                  rsp_data_ff.status       <= ST_FULL;
                  state_ff                 <= S_IDLE;
               end else begin
                  row_ff   <= row_ff + ROW_W'(1);
                  state_ff <= S_ALLOC_RD;
               end
            end
            S_ALLOC_MUL: begin
               prod_ff  <= PROD_W'({row_ff, bit_ff}) * PROD_W'(slot_size_ff);
               state_ff <= S_ALLOC_ADD;
            end
            S_ALLOC_ADD: begin
               // address wraps modulo 2^32
               rsp_valid_ff             <= 1'b1;
               rsp_data_ff.slot_address <= base_address_ff + ADDR_W'(prod_ff);
               rsp_data_ff.status       <= ST_ALLOCATED;
               state_ff                 <= S_IDLE;
            end
            S_FREE_MUL: begin
               span_ff  <= SPAN_W'(n_eff) * SPAN_W'(slot_size_ff);
               state_ff <= S_FREE_CHK;
            end
            S_FREE_CHK: begin
               if (fault) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.slot_address <= '0;
                  rsp_data_ff.status       <= ST_FAULT;
                  state_ff                 <= S_IDLE;
               end else begin
                  state_ff <= S_FREE_DIV;
               end
            end
            S_FREE_DIV: begin
               if (div_done) begin
                  row_ff   <= div_quot[SLOT_W-1:BIT_W];
                  bit_ff   <= div_quot[BIT_W-1:0];
                  state_ff <= S_FREE_RD;
               end
            end
            S_FREE_RD: begin
               state_ff <= S_FREE_WR;
            end
            S_FREE_WR: begin
               // freeing an already free slot still answers freed
               rsp_valid_ff             <= 1'b1;
               rsp_data_ff.slot_address <= '0;
               rsp_data_ff.status       <= ST_FREED;
               state_ff                 <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------------
   // a result beat only ever follows the return to idle
   `BSA_ASSERT_IMP(a_rsp_in_idle, clock, reset, rsp_valid_ff, state_ff == S_IDLE)
   // an accepted request either answers next cycle or keeps the block busy
   `BSA_ASSERT_NXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid_ff)
   // an allocation write-back clears exactly one free bit
   `BSA_ASSERT_IMP(a_alloc_one_bit, clock, reset, (state_ff == S_ALLOC_CHK) && mem_we,
                   $countones(mem_wdata) == $countones(rd_eff) - 1)
   // only an allocation carries a nonzero address
   `BSA_ASSERT_IMP(a_addr_zero, clock, reset,
                   rsp_valid_ff && (rsp_data_ff.status != ST_ALLOCATED),
                   rsp_data_ff.slot_address == '0)
   // the divider finishes only while the sequencer waits for it
   `BSA_ASSERT_IMP(a_div_owner, clock, reset, div_done, state_ff == S_FREE_DIV)

endmodule
